[design/m3i_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, register codes and transfer types of the 3x3 inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

   // element format and matrix shape
   localparam int ELEM_W  = 32;
   localparam int MAT_DIM = 3;
   localparam int ELEM_N  = MAT_DIM * MAT_DIM;
   localparam int TDATA_W = ELEM_N * ELEM_W;

   // exact intermediate widths: cofactor, determinant, divider remainder
   localparam int COF_W = 2 * ELEM_W + 1;
   localparam int DET_W = 3 * ELEM_W + 3;
   localparam int REM_W = DET_W + ELEM_W;

   // divider depth: one stage for the magnitude, one for the range check,
   // then one stage per quotient bit
   localparam int DIV_LAST = ELEM_W + 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int EPS_W      = 16;
   localparam logic CSR_IDX_EPSILON = 1'b0;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   // determinant facts that travel beside the lanes
   typedef struct packed {
      logic             valid;
      logic             sing;
      logic             dneg;
      logic [DET_W-1:0] den;
   } m3i_side_type;

   // what one divider lane hands to the merge stage
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [ELEM_W-1:0] quot;
   } m3i_quot_type;

endpackage

[design/m3i_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Input capture, cofactors, determinant and singular test, seven stages.
// ----------------------------------------------------------------------------
module m3i_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         en,
   input  logic                                         in_valid,
   input  logic [m3i_pkg::TDATA_W-1:0]                  in_data,
   input  logic [m3i_pkg::EPS_W-1:0]                    epsilon,
   output logic signed [m3i_pkg::COF_W-1:0]             cof_o [m3i_pkg::ELEM_N],
   output m3i_pkg::m3i_side_type                        side_o
);

   localparam int W   = m3i_pkg::ELEM_W;
   localparam int N   = m3i_pkg::ELEM_N;
   localparam int CW  = m3i_pkg::COF_W;
   localparam int DW  = m3i_pkg::DET_W;
   localparam int CARRY_N = 5;

   logic [6:0] valid_ff;

   logic signed [W-1:0]    a_ff [N];
   logic signed [2*W-1:0]  prod_ff [N][2];
   logic signed [W-1:0]    row_ff [2][m3i_pkg::MAT_DIM];
   logic signed [CW-1:0]   cof_in [N];
   logic signed [CW-1:0]   cof_ff [CARRY_N][N];
   logic signed [CW-1:0]   plo_ff [m3i_pkg::MAT_DIM];
   logic signed [CW-1:0]   phi_ff [m3i_pkg::MAT_DIM];
   logic signed [DW-1:0]   term_ff [m3i_pkg::MAT_DIM];
   logic signed [DW-1:0]   det_ff;
   logic signed [DW-1:0]   thr;
   m3i_pkg::m3i_side_type  side_ff;

   // advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   // capture the elements
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            a_ff[i] <= in_data[i*W +: W];
         end
      end
   end

   // two products per 2x2 minor
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int R1 = (r == 0) ? 1 : 0;
         localparam int R2 = (r == 2) ? 1 : 2;
         localparam int C1 = (c == 0) ? 1 : 0;
         localparam int C2 = (c == 2) ? 1 : 2;
         localparam int IX = r * 3 + c;
         localparam bit FLIP = ((r + c) % 2) == 1;

         always_ff @(posedge clock) begin
            if (en) begin
               prod_ff[IX][0] <= a_ff[R1*3+C1] * a_ff[R2*3+C2];
               prod_ff[IX][1] <= a_ff[R1*3+C2] * a_ff[R2*3+C1];
            end
         end

         // minor with the checkerboard sign
         always_comb begin
            if (FLIP) begin
               cof_in[IX] = CW'(prod_ff[IX][1]) - CW'(prod_ff[IX][0]);
            end else begin
               cof_in[IX] = CW'(prod_ff[IX][0]) - CW'(prod_ff[IX][1]);
            end
         end
      end
   end

   // carry row 0 and the cofactors down the pipe
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            row_ff[0][j] <= a_ff[j];
            row_ff[1][j] <= row_ff[0][j];
         end
         cof_ff[0] <= cof_in;
         for (int s = 1; s < CARRY_N; s++) begin
            cof_ff[s] <= cof_ff[s-1];
         end
      end
   end

   // row 0 expansion: split each cofactor into a low and a high part
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            plo_ff[j] <= row_ff[1][j] * $signed({1'b0, cof_ff[0][j][W-1:0]});
            phi_ff[j] <= row_ff[1][j] * $signed(cof_ff[0][j][CW-1:W]);
         end
      end
   end

   // recombine the parts, then sum the three terms
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= (DW'(phi_ff[j]) <<< W) + DW'(plo_ff[j]);
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   // singular when the determinant is zero or lies strictly inside +/- epsilon
   assign thr = $signed(DW'(epsilon) << (2 * FRAC_BITS));

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.dneg <= det_ff[DW-1];
         side_ff.den  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         side_ff.sing <= (det_ff == '0) || ((det_ff < thr) && (det_ff > -thr));
      end
   end

   always_comb begin
      side_o.valid = valid_ff[6];
      side_o.sing  = side_ff.sing;
      side_o.dneg  = side_ff.dneg;
      side_o.den   = side_ff.den;
   end

   assign cof_o = cof_ff[CARRY_N-1];

endmodule

[design/m3i_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_lane
// One restoring divider lane: |cofactor| * 2^(2F) / |det|, one bit a stage.
// ----------------------------------------------------------------------------
module m3i_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [m3i_pkg::COF_W-1:0]  cof_i,
   input  logic                              dneg_i,
   input  logic [m3i_pkg::DET_W-1:0]         den_i [1:m3i_pkg::DIV_LAST-1],
   output m3i_pkg::m3i_quot_type             quot_o
);

   localparam int W    = m3i_pkg::ELEM_W;
   localparam int CW   = m3i_pkg::COF_W;
   localparam int RW   = m3i_pkg::REM_W;
   localparam int LAST = m3i_pkg::DIV_LAST;

   logic [RW-1:0] rem_ff [1:LAST-1];
   logic [W-1:0]  q_ff   [2:LAST];
   logic          neg_ff [1:LAST];
   logic          ovf_ff [2:LAST];
   logic [CW-1:0] mag;

   assign mag = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);

   // scale the magnitude, fix the result sign
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[1] <= RW'(mag) << (2 * FRAC_BITS);
         neg_ff[1] <= cof_i[CW-1] ^ dneg_i;
      end
   end

   // quotient of 2^W or more saturates
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[2] <= rem_ff[1];
         neg_ff[2] <= neg_ff[1];
         ovf_ff[2] <= rem_ff[1] >= (RW'(den_i[1]) << W);
         q_ff[2]   <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 3; s <= LAST; s++) begin : g_step
      localparam int K = LAST - s;
      logic [RW-1:0] trial;
      logic          take;

      assign trial = RW'(den_i[s-1]) << K;
      assign take  = rem_ff[s-1] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (take ? (W'(1) << K) : '0);
         end
      end

      if (s < LAST) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? (rem_ff[s-1] - trial) : rem_ff[s-1];
            end
         end
      end
   end

   assign quot_o.neg  = neg_ff[LAST];
   assign quot_o.ovf  = ovf_ff[LAST];
   assign quot_o.quot = q_ff[LAST];

endmodule

[design/m3i_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_merge
// Saturates the nine lane quotients, swaps in the identity for a singular
// matrix and holds the result transaction.
// ----------------------------------------------------------------------------
module m3i_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  m3i_pkg::m3i_quot_type         quot_i [m3i_pkg::ELEM_N],
   input  logic                          sing_i,
   input  logic                          valid_i,
   output logic                          out_valid,
   output logic [m3i_pkg::TDATA_W-1:0]   out_data,
   output logic                          out_sing
);

   localparam int W = m3i_pkg::ELEM_W;
   localparam int N = m3i_pkg::ELEM_N;
   localparam logic [W-1:0] HALF = W'(1) << (W - 1);
   localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;

   logic [W-1:0]   elem_in [N];
   logic           valid_ff;
   logic [m3i_pkg::TDATA_W-1:0] data_ff;
   logic           sing_ff;

   // clamp each quotient to the signed element range, or give the identity when singular
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (sing_i) begin
            elem_in[i] = ((i % 4) == 0) ? ONE : '0;
         end else if (quot_i[i].neg) begin
            if (quot_i[i].ovf || (quot_i[i].quot > HALF)) begin
               elem_in[i] = HALF;
            end else begin
               elem_in[i] = W'(-quot_i[i].quot);
            end
         end else if (quot_i[i].ovf || quot_i[i].quot[W-1]) begin
            elem_in[i] = HALF - W'(1);
         end else begin
            elem_in[i] = quot_i[i].quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   // hold the result while the sink stalls
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= sing_i;
         for (int i = 0; i < N; i++) begin
            data_ff[i*W +: W] <= elem_in[i];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_sing  = sing_ff;

endmodule

[design/matrix3_inverse_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 Q16.16 matrix inverse by the adjugate, with a singular fallback.
// ----------------------------------------------------------------------------
// Takes one matrix transaction per clock while no stalled result waits:
// seven stages form the cofactors and the exact determinant, nine divider
// lanes then spend 34 stages, one scaling, one checking the range and one
// per quotient bit, for the nine elements side by side, and a final
// register saturates and holds the result. Throughput is one matrix per
// cycle whenever the sink takes results; a stalled result holds the whole
// pipeline. A determinant whose magnitude is below singular_epsilon
// returns the identity with tuser high.
// Write singular_epsilon only while idle.
module matrix3_inverse_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // a00..a22, 32 bits each, row major, a00 at the lowest bits
   input  logic [m3i_pkg::TDATA_W-1:0]         req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // r00..r22, 32 bits each, row major, r00 at the lowest bits
   output logic [m3i_pkg::TDATA_W-1:0]         rsp_tdata,
   // singular
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [m3i_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [m3i_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [m3i_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int N    = m3i_pkg::ELEM_N;
   localparam int LAST = m3i_pkg::DIV_LAST;

   logic                                en;
   logic [m3i_pkg::EPS_W-1:0]           eps_ff;
   logic signed [m3i_pkg::COF_W-1:0]    cof [N];
   m3i_pkg::m3i_side_type               side_front;
   m3i_pkg::m3i_side_type               side_ff [1:LAST];
   logic [m3i_pkg::DET_W-1:0]           den_line [1:LAST-1];
   m3i_pkg::m3i_quot_type               quot [N];

   // whole pipeline moves unless a result waits
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // configuration register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= m3i_pkg::EPS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == m3i_pkg::CSR_IDX_EPSILON)) begin
         eps_ff <= csr_pwdata[m3i_pkg::EPS_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == m3i_pkg::CSR_IDX_EPSILON) ?
                       m3i_pkg::CSR_DATA_W'(eps_ff) : '0;

   m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .epsilon  (eps_ff),
      .cof_o    (cof),
      .side_o   (side_front)
   );

   // delay the determinant facts alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= LAST; s++) begin
            side_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[1] <= side_front;
         for (int s = 2; s <= LAST; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int s = 1; s < LAST; s++) begin
         den_line[s] = side_ff[s].den;
      end
   end

   // lane for result (i, j) divides cofactor (j, i)
   for (genvar i = 0; i < 3; i++) begin : g_lane_row
      for (genvar j = 0; j < 3; j++) begin : g_lane_col
         m3i_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock  (clock),
            .en     (en),
            .cof_i  (cof[j*3+i]),
            .dneg_i (side_front.dneg),
            .den_i  (den_line),
            .quot_o (quot[i*3+j])
         );
      end
   end

   m3i_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .quot_i    (quot),
      .sing_i    (side_ff[LAST].sing),
      .valid_i   (side_ff[LAST].valid),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_sing  (rsp_tuser)
   );

endmodule

[design/m3i_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks of the 3x3 inverse core, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [m3i_pkg::TDATA_W-1:0]         req_tdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [m3i_pkg::TDATA_W-1:0]         rsp_tdata,
   input  logic                                rsp_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [m3i_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [m3i_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [m3i_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                csr_pready
);

   localparam int W = m3i_pkg::ELEM_W;
   localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] ZERO = '0;
   localparam logic [m3i_pkg::TDATA_W-1:0] IDENT =
      {ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE};

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // input side never blocks while no result waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // singular transaction carries the identity
   a_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == IDENT)
      else $error("singular result is not the identity");

   // reset leaves no result pending
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind matrix3_inverse_core m3i_checker #(.FRAC_BITS(FRAC_BITS)) u_m3i_checker (.*);
